// ----- hw/rtl/sync_length_xor_deframer_macros.svh -----
// Assertion macros shared by the deframer modules.
`ifndef SYNC_LENGTH_XOR_DEFRAMER_MACROS_SVH
`define SYNC_LENGTH_XOR_DEFRAMER_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define STXD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the following cycle.
`define STXD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/stxd_pkg.sv -----
// Types and constants shared by the sync/length/XOR deframer.
package stxd_pkg;

  localparam logic [7:0] SYNC_BYTE  = 8'h02;
  localparam logic [2:0] SYNC_COUNT = 3'd4;
  // index of the final length byte (four length bytes)
  localparam logic [1:0] LEN_LAST   = 2'd3;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2,
    PH_SUM  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       kind;
    logic       last;
    logic       ok;
  } res_t;

endpackage

// ----- hw/rtl/sync_length_xor_deframer.sv -----
// A payload or frame-end word passes through the output register, or the skid stage and then the output register.
// One input word per cycle while in_ready is high; the parser state updates on each accepted word.
// A two-entry output buffer keeps input ready while one result waits to be taken.
// Sync and length words give no output; the checksum word gives one frame-end word.
// Reset (rst, synchronous) returns to the sync hunt and empties the output buffer.
module sync_length_xor_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_kind,
  output logic       last_payload,
  output logic       checksum_ok
);

  logic           fire;
  logic           res_valid;
  stxd_pkg::res_t res;
  stxd_pkg::res_t out_data;

  assign fire = in_valid && in_ready;

  // parse each accepted word
  stxd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // hold results until taken
  stxd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (fire && res_valid),
    .push_data (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_byte     = out_data.data;
  assign out_kind     = out_data.kind;
  assign last_payload = out_data.last;
  assign checksum_ok  = out_data.ok;

endmodule

// ----- hw/rtl/stxd_core.sv -----
// Frame parser: sync hunt, length gather, payload pass and checksum compare.
`include "sync_length_xor_deframer_macros.svh"

module stxd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  output stxd_pkg::res_t    res
);

  stxd_pkg::phase_t phase, phase_next;
  logic [2:0]  sync_left, sync_left_next;
  logic [1:0]  len_seen, len_seen_next;
  logic [31:0] length_shift, length_shift_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;
  logic [7:0]  running_xor, running_xor_next;

  logic [2:0]  sync_dec;
  logic [31:0] rem_dec;

  assign sync_dec = sync_left - {2'b00, (sync_left != 3'd0)};
  assign rem_dec  = bytes_remaining - {31'd0, (bytes_remaining != 32'd0)};

  // next state and result for the current word
  always_comb begin
    phase_next           = phase;
    sync_left_next       = sync_left;
    len_seen_next        = len_seen;
    length_shift_next    = length_shift;
    bytes_remaining_next = bytes_remaining;
    running_xor_next     = running_xor;
    res_valid            = 1'b0;
    res.data             = 8'd0;
    res.kind             = stxd_pkg::KIND_PAYLOAD;
    res.last             = 1'b0;
    res.ok               = 1'b0;
    case (phase)
      stxd_pkg::PH_HUNT: begin
        if (rx_byte == stxd_pkg::SYNC_BYTE) begin
          sync_left_next = sync_dec;
          if (sync_dec == 3'd0) begin
            phase_next        = stxd_pkg::PH_LEN;
            len_seen_next     = 2'd0;
            length_shift_next = 32'd0;
          end
        end else begin
          sync_left_next = stxd_pkg::SYNC_COUNT;
        end
      end
      stxd_pkg::PH_LEN: begin
        length_shift_next = {length_shift[23:0], rx_byte};
        if (len_seen == stxd_pkg::LEN_LAST) begin
          len_seen_next        = 2'd0;
          bytes_remaining_next = length_shift_next;
          running_xor_next     = 8'd0;
          phase_next = (length_shift_next == 32'd0) ? stxd_pkg::PH_SUM : stxd_pkg::PH_PAY;
        end else begin
          len_seen_next = len_seen + 2'd1;
        end
      end
      stxd_pkg::PH_PAY: begin
        running_xor_next     = running_xor ^ rx_byte;
        bytes_remaining_next = rem_dec;
        res_valid            = 1'b1;
        res.data             = rx_byte;
        res.last             = (rem_dec == 32'd0);
        if (rem_dec == 32'd0) begin
          phase_next = stxd_pkg::PH_SUM;
        end
      end
      stxd_pkg::PH_SUM: begin
        res_valid        = 1'b1;
        res.kind         = stxd_pkg::KIND_END;
        res.ok           = (rx_byte == running_xor);
        running_xor_next = 8'd0;
        phase_next       = stxd_pkg::PH_HUNT;
        sync_left_next   = stxd_pkg::SYNC_COUNT;
      end
      default: begin
        phase_next = stxd_pkg::PH_HUNT;
      end
    endcase
  end

  // advance state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= stxd_pkg::PH_HUNT;
      sync_left       <= stxd_pkg::SYNC_COUNT;
      len_seen        <= 2'd0;
      length_shift    <= 32'd0;
      bytes_remaining <= 32'd0;
      running_xor     <= 8'd0;
    end else if (fire) begin
      phase           <= phase_next;
      sync_left       <= sync_left_next;
      len_seen        <= len_seen_next;
      length_shift    <= length_shift_next;
      bytes_remaining <= bytes_remaining_next;
      running_xor     <= running_xor_next;
    end
  end

  `STXD_ASSERT_NOW(a_pay_nonzero, phase == stxd_pkg::PH_PAY, bytes_remaining != 32'd0, "payload phase with no bytes left")
  `STXD_ASSERT_NOW(a_len_synced, phase == stxd_pkg::PH_LEN, sync_left == 3'd0, "length phase without full sync run")
  `STXD_ASSERT_NEXT(a_end_rehunt, fire && phase == stxd_pkg::PH_SUM, phase == stxd_pkg::PH_HUNT && sync_left == stxd_pkg::SYNC_COUNT && running_xor == 8'd0, "checksum word did not restart hunt")

endmodule

// ----- hw/rtl/stxd_skid.sv -----
// Two-entry result buffer: output register plus skid stage.
`include "sync_length_xor_deframer_macros.svh"

module stxd_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  stxd_pkg::res_t    push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output stxd_pkg::res_t    out_data
);

  logic           skid_valid;
  stxd_pkg::res_t skid_data;
  logic           pop;

  assign pop   = out_valid && out_ready;
  assign space = !skid_valid;

  // control: refill output from skid first, else from the incoming word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  `STXD_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid, "skid holds a word while output is empty")
  `STXD_ASSERT_NEXT(a_skid_drains, skid_valid && pop, out_valid && !skid_valid, "skid word not moved to output")

endmodule
